// ===== rtl/core/rdo_pkg.sv =====
// Shared types and constants for the RTP dump deframer with timestamp offset.
package rdo_pkg;

    localparam int OFFSET_W     = 48;
    localparam int MIN_RTP_LEN  = 12;
    localparam int STAMP_FIRST  = 4;
    localparam int STAMP_LAST   = 7;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int RECIP_SHIFT  = 37;
    localparam logic [31:0] RECIP_45 = 32'd3054198967;

    typedef enum logic [1:0] {
        KIND_PACKET    = 2'd0,
        KIND_SHORT     = 2'd1,
        KIND_END_OK    = 2'd2,
        KIND_END_EMPTY = 2'd3
    } kind_t;

    typedef struct packed {
        logic        pkt_valid;
        logic        pkt_good;
        logic [31:0] stamp;
        logic [15:0] length;
        logic        end_valid;
        logic        bad;
    } event_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QUEUE_AW:0] count;
    } qstat_t;

endpackage

// ===== rtl/core/rtp_dump_deframer_offset.sv =====
// Top level of the length-prefixed RTP dump deframer with running timestamp offset.
// Accepts one byte item per cycle; input stalls only when the four-entry event queue is full.
// Short, end and first-packet records pass the event queue, the working registers and the result
// register; later good packets also pass the back end's multiply and offset-add states first.
// An end summary sharing an item with a packet follows that record as a separate end record.
// Reset: rst_n asynchronous active low clears parser, queue, counters, offset and output valid.
module rtp_dump_deframer_offset (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] rtp_timestamp, [79:32] offset, [95:80] packet_length,
    // [127:96] packet_count, [143:128] skipped_count, [144] bad_framing, [151:145] zero
    output logic [151:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast
);
    import rdo_pkg::*;

    event_t              front_ev;
    event_t              head_ev;
    qstat_t              q_stat;
    logic                push;
    logic                pop;
    logic [31:0]         out_stamp;
    logic [OFFSET_W-1:0] out_offset;
    logic [15:0]         out_length;
    logic [31:0]         out_count;
    logic [15:0]         out_skip;
    logic                out_bad;

    rdo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .data_byte   (s_axis_tdata),
        .has_byte    (s_axis_tuser[0]),
        .end_of_file (s_axis_tlast),
        .q_stat      (q_stat),
        .push        (push),
        .ev          (front_ev)
    );

    rdo_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_ev),
        .pop     (pop),
        .rd_data (head_ev),
        .stat    (q_stat)
    );

    rdo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_ev),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_stamp  (out_stamp),
        .out_offset (out_offset),
        .out_length (out_length),
        .out_count  (out_count),
        .out_skip   (out_skip),
        .out_bad    (out_bad),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_bad, out_skip, out_count, out_length, out_offset, out_stamp};

    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("event queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_END_OK || m_axis_tuser == KIND_END_EMPTY)
        |-> m_axis_tlast)
        else $error("end summary not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_END_EMPTY) |-> (m_axis_tdata[127:96] == 32'd0))
        else $error("empty end summary with nonzero packet count");

endmodule

// ===== rtl/core/rdo_front.sv =====
// Front end: byte parser that frames packets and queues packet and end events.
module rdo_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic            has_byte,
    input  logic            end_of_file,
    input  rdo_pkg::qstat_t q_stat,
    output logic            push,
    output rdo_pkg::event_t ev
);
    import rdo_pkg::*;

    typedef enum logic [3:0] {
        PH_LEN_HI = 4'b0001,
        PH_LEN_LO = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] idx_inc;
    logic [15:0] len_lo;
    logic [31:0] stamp_reg, stamp_next;
    logic        ferr_reg, ferr_next;
    logic        accept;
    logic        pkt_done;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign idx_inc  = idx_reg + 16'd1;
    assign len_lo   = {len_reg[15:8], data_byte};

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        stamp_next = stamp_reg;
        ferr_next  = ferr_reg;
        pkt_done   = 1'b0;
        if (accept && has_byte)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    len_next   = {data_byte, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = len_lo;
                    if (len_lo == 16'd0)
                    begin
                        ferr_next  = 1'b1;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        idx_next   = 16'd0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (idx_reg >= 16'(STAMP_FIRST) && idx_reg <= 16'(STAMP_LAST))
                        stamp_next = {stamp_reg[23:0], data_byte};
                    idx_next = idx_inc;
                    if (idx_inc == len_reg)
                    begin
                        pkt_done   = 1'b1;
                        phase_next = PH_LEN_HI;
                    end
                end
                default:
                begin
                end
            endcase
        end

        ev.pkt_valid = pkt_done;
        ev.pkt_good  = len_reg >= 16'(MIN_RTP_LEN);
        ev.stamp     = stamp_next;
        ev.length    = len_reg;
        ev.end_valid = end_of_file;
        ev.bad       = ferr_next || (phase_next == PH_BODY);

        if (accept && end_of_file)
        begin
            phase_next = PH_LEN_HI;
            len_next   = 16'd0;
            idx_next   = 16'd0;
            stamp_next = 32'd0;
            ferr_next  = 1'b0;
        end
    end

    assign push = accept && (pkt_done || end_of_file);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_HI;
            len_reg   <= 16'd0;
            idx_reg   <= 16'd0;
            stamp_reg <= 32'd0;
            ferr_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            stamp_reg <= stamp_next;
            ferr_reg  <= ferr_next;
        end
    end

endmodule

// ===== rtl/core/rdo_queue.sv =====
// Event queue between the parser and the offset back end.
module rdo_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rdo_pkg::event_t wr_data,
    input  logic            pop,
    output rdo_pkg::event_t rd_data,
    output rdo_pkg::qstat_t stat
);
    import rdo_pkg::*;

    event_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_AW+1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.empty = count_reg == '0;
    assign stat.full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/rdo_back.sv =====
// Back end: timestamp delta, divide by 90, running offset, counters, result register.
module rdo_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdo_pkg::event_t               head,
    input  rdo_pkg::qstat_t               q_stat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_kind,
    output logic [31:0]                   out_stamp,
    output logic [rdo_pkg::OFFSET_W-1:0]  out_offset,
    output logic [15:0]                   out_length,
    output logic [31:0]                   out_count,
    output logic [15:0]                   out_skip,
    output logic                          out_bad,
    output logic                          out_last
);
    import rdo_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_ACC  = 5'b00100,
        B_PKT  = 5'b01000,
        B_END  = 5'b10000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic                w_good_reg, w_end_reg, w_bad_reg, w_neg_reg;
    logic [31:0]         w_stamp_reg, w_end_stamp_reg, w_mag_reg, w_count_reg;
    logic [15:0]         w_len_reg, w_skip_reg;
    logic [62:0]         prod_reg, prod_next;
    logic [31:0]         prev_stamp_reg, good_count_reg;
    logic [15:0]         short_count_reg;
    logic [OFFSET_W-1:0] offset_reg, sum_offset, quot_ext;

    logic                out_valid_reg, out_bad_reg, out_last_reg;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [31:0]         out_stamp_reg, out_stamp_next, out_count_reg;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [15:0]         out_length_reg, out_length_next, out_skip_reg;
    logic                out_bad_next, out_last_next;

    logic        load_ok, fin_acc, fin_pkt, fin_end, free, fetch;
    logic [32:0] diff33;
    logic [31:0] diff, mag, gc_after, end_stamp;
    logic [15:0] sc_after;
    logic        neg, is_good, is_short;

    assign load_ok = !out_valid_reg || out_ready;
    assign fin_acc = (state_reg == B_ACC) && load_ok;
    assign fin_pkt = (state_reg == B_PKT) && load_ok;
    assign fin_end = (state_reg == B_END) && load_ok;
    assign free    = (state_reg == B_IDLE) || ((fin_acc || fin_pkt) && !w_end_reg) || fin_end;
    assign fetch   = free && !q_stat.empty;
    assign pop     = fetch;

    assign diff33    = {1'b0, head.stamp} - {1'b0, prev_stamp_reg};
    assign diff      = diff33[31:0];
    assign neg       = diff[31] && ((diff != 32'h8000_0000) || !diff33[32]);
    assign mag       = diff[31] ? (32'd0 - diff) : diff;
    assign is_good   = head.pkt_valid && head.pkt_good;
    assign is_short  = head.pkt_valid && !head.pkt_good;
    assign gc_after  = (is_good && good_count_reg != 32'hFFFF_FFFF) ?
                       good_count_reg + 32'd1 : good_count_reg;
    assign sc_after  = (is_short && short_count_reg != 16'hFFFF) ?
                       short_count_reg + 16'd1 : short_count_reg;
    assign end_stamp = is_good ? head.stamp : prev_stamp_reg;

    assign prod_next  = w_mag_reg[31:1] * RECIP_45;
    assign quot_ext   = OFFSET_W'(prod_reg[62:RECIP_SHIFT]);
    assign sum_offset = w_neg_reg ? offset_reg - quot_ext : offset_reg + quot_ext;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_MUL:   state_next = B_ACC;
            B_ACC:   if (load_ok && w_end_reg) state_next = B_END;
            B_PKT:   if (load_ok && w_end_reg) state_next = B_END;
            default: state_next = state_reg;
        endcase
        if (free)
        begin
            if (!fetch)
                state_next = B_IDLE;
            else if (is_good && good_count_reg != 32'd0)
                state_next = B_MUL;
            else if (head.pkt_valid)
                state_next = B_PKT;
            else
                state_next = B_END;
        end
    end

    always_comb
    begin
        out_kind_next   = KIND_END_OK;
        out_stamp_next  = w_end_stamp_reg;
        out_offset_next = offset_reg;
        out_length_next = 16'd0;
        out_bad_next    = w_bad_reg;
        out_last_next   = 1'b1;
        if (fin_acc)
        begin
            out_kind_next   = KIND_PACKET;
            out_stamp_next  = w_stamp_reg;
            out_offset_next = sum_offset;
            out_length_next = w_len_reg;
            out_bad_next    = 1'b0;
            out_last_next   = !w_end_reg;
        end
        else if (fin_pkt)
        begin
            out_kind_next   = w_good_reg ? KIND_PACKET : KIND_SHORT;
            out_stamp_next  = w_good_reg ? w_stamp_reg : 32'd0;
            out_length_next = w_len_reg;
            out_bad_next    = 1'b0;
            out_last_next   = !w_end_reg;
        end
        else if (w_count_reg == 32'd0)
        begin
            out_kind_next = KIND_END_EMPTY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            w_good_reg      <= head.pkt_good;
            w_end_reg       <= head.end_valid;
            w_bad_reg       <= head.bad;
            w_neg_reg       <= neg;
            w_mag_reg       <= mag;
            w_stamp_reg     <= head.stamp;
            w_end_stamp_reg <= end_stamp;
            w_len_reg       <= head.length;
            w_count_reg     <= gc_after;
            w_skip_reg      <= sc_after;
        end
        if (state_reg == B_MUL)
            prod_reg <= prod_next;
        if (load_ok)
        begin
            out_kind_reg   <= out_kind_next;
            out_stamp_reg  <= out_stamp_next;
            out_offset_reg <= out_offset_next;
            out_length_reg <= out_length_next;
            out_count_reg  <= w_count_reg;
            out_skip_reg   <= w_skip_reg;
            out_bad_reg    <= out_bad_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            prev_stamp_reg  <= 32'd0;
            good_count_reg  <= 32'd0;
            short_count_reg <= 16'd0;
            offset_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fetch)
            begin
                if (head.end_valid)
                begin
                    prev_stamp_reg  <= 32'd0;
                    good_count_reg  <= 32'd0;
                    short_count_reg <= 16'd0;
                end
                else
                begin
                    prev_stamp_reg  <= end_stamp;
                    good_count_reg  <= gc_after;
                    short_count_reg <= sc_after;
                end
            end
            if (fin_acc)
                offset_reg <= sum_offset;
            else if (fin_end)
                offset_reg <= '0;
            if (load_ok)
                out_valid_reg <= fin_acc || fin_pkt || fin_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_stamp  = out_stamp_reg;
    assign out_offset = out_offset_reg;
    assign out_length = out_length_reg;
    assign out_count  = out_count_reg;
    assign out_skip   = out_skip_reg;
    assign out_bad    = out_bad_reg;
    assign out_last   = out_last_reg;

endmodule
